[rtl/ccm_pkg.sv]
// Package for the curvature color mapper: register indexes, mode codes,
// palette tables and the color blend function. No dependencies.
package ccm_pkg;

    typedef enum logic [1:0] {
        REG_CLAMP_MODE,
        REG_COLOR_MODE,
        REG_RANGE_LOW,
        REG_RANGE_INV_WIDTH
    } cfg_reg_t;

    localparam logic [1:0] CLAMP_NONE     = 2'd0;
    localparam logic [1:0] CLAMP_POS_ONLY = 2'd1;
    localparam logic [1:0] CLAMP_NEG_ONLY = 2'd2;

    localparam logic [1:0] COLOR_GRAY      = 2'd0;
    localparam logic [1:0] COLOR_RGB       = 2'd1;
    localparam logic [1:0] COLOR_RED_BLUE  = 2'd2;

    localparam logic [31:0] INV_WIDTH_RESET = 32'd65536;
    localparam logic [16:0] T_ONE           = 17'd65536;
    localparam logic [8:0]  CH_FULL         = 9'd256;
    localparam logic [8:0]  CH_HALF         = 9'd128;

    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } rgb_t;

    function automatic rgb_t pal_neg(input logic [1:0] sel);
        rgb_t c;
        case (sel)
            COLOR_RGB:      c = '{r: CH_FULL, g: 9'd0, b: 9'd0};
            COLOR_RED_BLUE: c = '{r: CH_FULL, g: 9'd0, b: 9'd0};
            default:        c = '{r: 9'd0, g: 9'd0, b: 9'd0};
        endcase
        return c;
    endfunction

    function automatic rgb_t pal_zero(input logic [1:0] sel);
        rgb_t c;
        case (sel)
            COLOR_RGB:      c = '{r: 9'd0, g: CH_FULL, b: 9'd0};
            COLOR_RED_BLUE: c = '{r: 9'd0, g: 9'd0, b: 9'd0};
            default:        c = '{r: CH_HALF, g: CH_HALF, b: CH_HALF};
        endcase
        return c;
    endfunction

    function automatic rgb_t pal_pos(input logic [1:0] sel);
        rgb_t c;
        case (sel)
            COLOR_RGB:      c = '{r: 9'd0, g: 9'd0, b: CH_FULL};
            COLOR_RED_BLUE: c = '{r: 9'd0, g: 9'd0, b: CH_FULL};
            default:        c = '{r: CH_FULL, g: CH_FULL, b: CH_FULL};
        endcase
        return c;
    endfunction

    // z + (e - z) * t, t in Q1.16, rounded half up; never leaves 0..256
    function automatic logic [8:0] blend(input logic [8:0] z, input logic [8:0] e,
                                         input logic [16:0] t);
        logic signed [26:0] acc;
        acc = $signed({2'b00, z, 16'h0000})
            + ($signed({1'b0, e}) - $signed({1'b0, z})) * $signed({1'b0, t})
            + 27'sd32768;
        return acc[24:16];
    endfunction

endpackage

[rtl/curvature_color_mapper.sv]
// Curvature color mapper top level: five-stage pipeline from vertex curvatures
// to a diverging RGB color. Depends on ccm_pkg.
// One item per cycle while out_stall is low; a beat passes the s1, s2, s3, s4
// and output registers. Stage 1 weights each vertex curvature (three 32x17
// multiplies), stage 2 sums, rounds and saturates, stage 3 takes the magnitude
// and subtracts the ramp floor, stage 4 runs the 32x32 ramp multiply, stage 5
// saturates t and blends the palette into the output register. Each stage
// advances when it is empty or the stage after it advances, so bubbles close up
// under out_stall and in_stall rises only when every stage holds a beat.
// Registers are written through the cfg port, which is always ready; write them
// only while the pipeline is empty.
module curvature_color_mapper
    import ccm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] curvature_a,
    input  logic signed [31:0] curvature_b,
    input  logic signed [31:0] curvature_c,
    input  logic [16:0]        weight_a,
    input  logic [16:0]        weight_b,
    input  logic [16:0]        weight_c,
    input  logic               triangle_valid,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [8:0]         red,
    output logic [8:0]         green,
    output logic [8:0]         blue
);

    // configuration registers
    logic [1:0]  clamp_mode_reg;
    logic [1:0]  color_mode_reg;
    logic [30:0] range_low_reg;
    logic [31:0] range_inv_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_mode_reg      <= CLAMP_NONE;
            color_mode_reg      <= COLOR_GRAY;
            range_low_reg       <= '0;
            range_inv_width_reg <= INV_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLAMP_MODE:      clamp_mode_reg      <= cfg_data[1:0];
                REG_COLOR_MODE:      color_mode_reg      <= cfg_data[1:0];
                REG_RANGE_LOW:       range_low_reg       <= cfg_data[30:0];
                REG_RANGE_INV_WIDTH: range_inv_width_reg <= cfg_data;
                default:             range_low_reg       <= range_low_reg;
            endcase
        end
    end

    // stage valids and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !out_valid_reg || !out_stall;
    assign en4      = !s4_valid_reg  || en5;
    assign en3      = !s3_valid_reg  || en4;
    assign en2      = !s2_valid_reg  || en3;
    assign en1      = !s1_valid_reg  || en2;
    assign in_stall = !en1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg  <= in_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) s4_valid_reg  <= s3_valid_reg;
            if (en5) out_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: pre-clamp and weight each vertex
    logic signed [31:0] curv_in [3];
    logic        [16:0] wt_in   [3];
    logic signed [31:0] curv_cl [3];
    logic signed [48:0] prod_next [3];
    logic signed [48:0] prod_reg  [3];
    logic               tri_reg;

    assign curv_in[0] = curvature_a;
    assign curv_in[1] = curvature_b;
    assign curv_in[2] = curvature_c;
    assign wt_in[0]   = weight_a;
    assign wt_in[1]   = weight_b;
    assign wt_in[2]   = weight_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            curv_cl[i] = curv_in[i];
            if (clamp_mode_reg == CLAMP_POS_ONLY && curv_in[i] < 0)
                curv_cl[i] = '0;
            if (clamp_mode_reg == CLAMP_NEG_ONLY && curv_in[i] > 0)
                curv_cl[i] = '0;
            prod_next[i] = curv_cl[i] * $signed({1'b0, wt_in[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= prod_next[i];
            tri_reg <= triangle_valid;
        end
    end

    // stage 2: sum, round half up to Q16.16, saturate to 32 bits; zero off a triangle
    logic signed [50:0] acc;
    logic signed [34:0] acc_sh;
    logic signed [31:0] sum_next;
    logic signed [31:0] sum_reg;

    always_comb
    begin
        acc    = 51'(prod_reg[0]) + 51'(prod_reg[1]) + 51'(prod_reg[2]) + 51'sd32768;
        acc_sh = acc[50:16];
        if (!tri_reg)
            sum_next = '0;
        else if (acc_sh[34:31] == 4'b0000 || acc_sh[34:31] == 4'b1111)
            sum_next = acc_sh[31:0];
        else if (acc_sh[34])
            sum_next = 32'sh8000_0000;
        else
            sum_next = 32'sh7FFF_FFFF;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
            sum_reg <= sum_next;
    end

    // stage 3: magnitude above the ramp floor
    logic [31:0] mag;
    logic [31:0] diff_next;
    logic [31:0] diff_reg;
    logic        neg_s3_reg;

    always_comb
    begin
        mag = sum_reg[31] ? 32'(-sum_reg) : 32'(sum_reg);
        if (mag > {1'b0, range_low_reg})
            diff_next = mag - {1'b0, range_low_reg};
        else
            diff_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            diff_reg   <= diff_next;
            neg_s3_reg <= sum_reg[31];
        end
    end

    // stage 4: ramp multiply
    logic [63:0] ramp_reg;
    logic        neg_s4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ramp_reg   <= diff_reg * range_inv_width_reg;
            neg_s4_reg <= neg_s3_reg;
        end
    end

    // stage 5: saturate t and blend toward the end color
    logic [16:0] t_val;
    rgb_t        zero_col;
    rgb_t        end_col;
    rgb_t        col_next;
    rgb_t        col_reg;

    always_comb
    begin
        t_val    = (|ramp_reg[63:32]) ? T_ONE : {1'b0, ramp_reg[31:16]};
        zero_col = pal_zero(color_mode_reg);
        end_col  = neg_s4_reg ? pal_neg(color_mode_reg) : pal_pos(color_mode_reg);
        col_next.r = blend(zero_col.r, end_col.r, t_val);
        col_next.g = blend(zero_col.g, end_col.g, t_val);
        col_next.b = blend(zero_col.b, end_col.b, t_val);
    end

    always_ff @(posedge clk)
    begin
        if (en5)
            col_reg <= col_next;
    end

    assign red   = col_reg.r;
    assign green = col_reg.g;
    assign blue  = col_reg.b;

    // checks
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted beat did not reach stage 1");

    a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while output register empty");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= CH_FULL) && (green <= CH_FULL) && (blue <= CH_FULL))
        else $error("color channel above full scale");

    a_red_blue_no_green: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && color_mode_reg == COLOR_RED_BLUE |-> green == 9'd0)
        else $error("green channel set in red-black-blue palette");

endmodule

[test/ccm_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the curvature color mapper: tracks register writes, predicts the
// color of every accepted input beat and compares the output beats in order.
// Depends on ccm_pkg for register indexes and mode codes.
module ccm_checker
    import ccm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] curvature_a,
    input  logic signed [31:0] curvature_b,
    input  logic signed [31:0] curvature_c,
    input  logic [16:0]        weight_a,
    input  logic [16:0]        weight_b,
    input  logic [16:0]        weight_c,
    input  logic               triangle_valid,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [8:0]         red,
    input  logic [8:0]         green,
    input  logic [8:0]         blue,

    output int                 fail_count,
    output int                 pending
);

    logic [1:0]  clamp_sel;
    logic [1:0]  color_sel;
    logic [30:0] ramp_floor;
    logic [31:0] ramp_gain;
    rgb_t        color_queue[$];
    int          fail_total;

    function automatic longint clamp_vertex(input logic signed [31:0] curv);
        longint v;
        v = curv;
        if (clamp_sel == CLAMP_POS_ONLY && v < 0)
            return 0;
        if (clamp_sel == CLAMP_NEG_ONLY && v > 0)
            return 0;
        return v;
    endfunction

    function automatic logic [8:0] mix_channel(input int from_c, input int to_c,
                                               input longint ramp_t);
        longint acc;
        acc = longint'(from_c) * 65536 + longint'(to_c - from_c) * ramp_t + 32768;
        if (acc < 0)
            acc = 0;
        return acc[24:16];
    endfunction

    function automatic rgb_t predict_color(input logic signed [31:0] ca, cb, cc,
                                           input logic [16:0] wa, wb, wc,
                                           input logic on_tri);
        longint            acc;
        longint            sum;
        longint unsigned   mag;
        longint unsigned   prod;
        longint            ramp_t;
        bit                neg;
        rgb_t              zero_c;
        rgb_t              neg_c;
        rgb_t              pos_c;
        rgb_t              end_c;
        rgb_t              res;
        sum = 0;
        if (on_tri)
        begin
            acc = clamp_vertex(ca) * longint'(wa) + clamp_vertex(cb) * longint'(wb)
                + clamp_vertex(cc) * longint'(wc) + 32768;
            // arithmetic shift floors, which rounds half toward plus infinity here
            sum = acc >>> 16;
            if (sum > 64'sd2147483647)
                sum = 64'sd2147483647;
            if (sum < -64'sd2147483648)
                sum = -64'sd2147483648;
        end
        neg = sum < 0;
        mag = neg ? -sum : sum;
        ramp_t = 0;
        if (mag > ramp_floor)
        begin
            prod = (mag - ramp_floor) * ramp_gain;
            if (prod >= 64'h1_0000_0000)
                ramp_t = 65536;
            else
                ramp_t = prod >> 16;
        end
        case (color_sel)
            COLOR_RGB:
            begin
                neg_c  = '{r: 9'd256, g: 9'd0,   b: 9'd0};
                zero_c = '{r: 9'd0,   g: 9'd256, b: 9'd0};
                pos_c  = '{r: 9'd0,   g: 9'd0,   b: 9'd256};
            end
            COLOR_RED_BLUE:
            begin
                neg_c  = '{r: 9'd256, g: 9'd0, b: 9'd0};
                zero_c = '{r: 9'd0,   g: 9'd0, b: 9'd0};
                pos_c  = '{r: 9'd0,   g: 9'd0, b: 9'd256};
            end
            default:
            begin
                neg_c  = '{r: 9'd0,   g: 9'd0,   b: 9'd0};
                zero_c = '{r: 9'd128, g: 9'd128, b: 9'd128};
                pos_c  = '{r: 9'd256, g: 9'd256, b: 9'd256};
            end
        endcase
        end_c = neg ? neg_c : pos_c;
        res.r = mix_channel(zero_c.r, end_c.r, ramp_t);
        res.g = mix_channel(zero_c.g, end_c.g, ramp_t);
        res.b = mix_channel(zero_c.b, end_c.b, ramp_t);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rgb_t       want;
        logic [8:0] want_f[3];
        logic [8:0] got_f[3];
        string      field_name[3];
        int         k;
        if (!rst_n)
        begin
            clamp_sel  = CLAMP_NONE;
            color_sel  = COLOR_GRAY;
            ramp_floor = '0;
            ramp_gain  = INV_WIDTH_RESET;
            color_queue.delete();
            fail_total = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            field_name[0] = "red";
            field_name[1] = "green";
            field_name[2] = "blue";
            // check the result beat first; it never belongs to this edge's input
            if (out_valid && !out_stall)
            begin
                if (color_queue.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected color beat r=%0d g=%0d b=%0d",
                             $time, red, green, blue);
                end
                else
                begin
                    want = color_queue.pop_front();
                    want_f[0] = want.r;
                    want_f[1] = want.g;
                    want_f[2] = want.b;
                    got_f[0]  = red;
                    got_f[1]  = green;
                    got_f[2]  = blue;
                    for (k = 0; k < 3; k++)
                    begin
                        if (got_f[k] !== want_f[k])
                        begin
                            fail_total++;
                            $display("%0t: %s mismatch, expected %0d, got %0d",
                                     $time, field_name[k], want_f[k], got_f[k]);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                color_queue.push_back(predict_color(curvature_a, curvature_b,
                                                    curvature_c, weight_a, weight_b,
                                                    weight_c, triangle_valid));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CLAMP_MODE:      clamp_sel  = cfg_data[1:0];
                    REG_COLOR_MODE:      color_sel  = cfg_data[1:0];
                    REG_RANGE_LOW:       ramp_floor = cfg_data[30:0];
                    REG_RANGE_INV_WIDTH: ramp_gain  = cfg_data;
                    default:             ;
                endcase
            end
            fail_count <= fail_total;
            pending    <= color_queue.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the curvature color mapper test: clock, reset, register phases,
// directed and random curvature beats, output backpressure and the verdict.
// Depends on ccm_pkg, curvature_color_mapper and ccm_checker.
module testbench;
    import ccm_pkg::*;

    localparam int RANDOM_PHASES   = 12;
    localparam int BEATS_PER_PHASE = 102;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic [16:0]        wa;
        logic [16:0]        wb;
        logic [16:0]        wc;
        logic               on_tri;
    } sample_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] curvature_a;
    logic signed [31:0] curvature_b;
    logic signed [31:0] curvature_c;
    logic [16:0]        weight_a;
    logic [16:0]        weight_b;
    logic [16:0]        weight_c;
    logic               triangle_valid;
    logic               out_valid;
    logic               out_stall;
    logic [8:0]         red;
    logic [8:0]         green;
    logic [8:0]         blue;

    int                 fail_count;
    int                 pending;
    bit                 idle_on;
    bit                 stall_on;

    curvature_color_mapper u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .curvature_a    (curvature_a),
        .curvature_b    (curvature_b),
        .curvature_c    (curvature_c),
        .weight_a       (weight_a),
        .weight_b       (weight_b),
        .weight_c       (weight_c),
        .triangle_valid (triangle_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

    ccm_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .curvature_a    (curvature_a),
        .curvature_b    (curvature_b),
        .curvature_c    (curvature_c),
        .weight_a       (weight_a),
        .weight_b       (weight_b),
        .weight_c       (weight_c),
        .triangle_valid (triangle_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic sample_t make_sample(input logic signed [31:0] ca, cb, cc,
                                            input logic [16:0] wa, wb, wc,
                                            input logic on_tri);
        sample_t s;
        s.ca = ca;
        s.cb = cb;
        s.cc = cc;
        s.wa = wa;
        s.wb = wb;
        s.wc = wc;
        s.on_tri = on_tri;
        return s;
    endfunction

    function automatic logic signed [31:0] random_curvature();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      rest;
        s.ca = random_curvature();
        s.cb = random_curvature();
        s.cc = random_curvature();
        if ($urandom_range(0, 7) == 0)
        begin
            s.wa = 17'($urandom);
            s.wb = 17'($urandom);
            s.wc = 17'($urandom);
        end
        else
        begin
            // barycentric weights that add up to one
            s.wa = 17'($urandom_range(0, 65536));
            rest = 65536 - int'(s.wa);
            s.wb = 17'($urandom_range(0, rest));
            s.wc = 17'(rest - int'(s.wb));
        end
        s.on_tri = $urandom_range(0, 9) != 0;
        return s;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // hold the input idle and wait for the pipeline to empty
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] clamp_d, color_d, low_d, gain_d);
        drain();
        write_reg(REG_CLAMP_MODE, clamp_d);
        write_reg(REG_COLOR_MODE, color_d);
        write_reg(REG_RANGE_LOW, low_d);
        write_reg(REG_RANGE_INV_WIDTH, gain_d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        curvature_a    <= s.ca;
        curvature_b    <= s.cb;
        curvature_c    <= s.cc;
        weight_a       <= s.wa;
        weight_b       <= s.wb;
        weight_c       <= s.wc;
        triangle_valid <= s.on_tri;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [31:0] random_low();
        case ($urandom_range(0, 4))
            0:       return $urandom & 32'h8000_0000;
            1:       return 32'h7FFF_FFFF | ($urandom & 32'h8000_0000);
            2:       return $urandom;
            default: return $urandom_range(0, 32'h40000) | ($urandom & 32'h8000_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return INV_WIDTH_RESET;
            default: return $urandom_range(32'h1000, 32'h40000);
        endcase
    endfunction

    // output backpressure in bursts
    initial
    begin : backpressure
        int stall_len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                stall_len = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** curvature_color_mapper: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int n;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_CLAMP_MODE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        curvature_a    = '0;
        curvature_b    = '0;
        curvature_c    = '0;
        weight_a       = '0;
        weight_b       = '0;
        weight_c       = '0;
        triangle_valid = 1'b0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: no pre-clamp, gray palette, unit ramp from zero
        send_sample(make_sample(0, 0, 0, 0, 0, 0, 1'b1));
        send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                131071, 131071, 131071, 1'b0));
        send_sample(make_sample(1, 0, 0, 32768, 0, 0, 1'b1));
        send_sample(make_sample(-1, 0, 0, 32768, 0, 0, 1'b1));
        send_sample(make_sample(-3, 0, 0, 32768, 0, 0, 1'b1));
        send_sample(make_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000,
                                131071, 131071, 131071, 1'b1));
        send_sample(make_sample(32'sh0000_8000, 0, 0, 65536, 0, 0, 1'b1));
        send_sample(make_sample(-32'sh0000_8000, 0, 0, 65536, 0, 0, 1'b1));
        send_sample(make_sample(32'sh0002_0000, -32'sh0003_0000, 32'sh7FFF_FFFF,
                                21845, 21845, 21846, 1'b1));

        // unused clamp and color codes, zero inverse width
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_sample(make_sample(32'sh7FFF_FFFF, 0, 0, 65536, 0, 0, 1'b1));
        send_sample(make_sample(32'sh8000_0000, 0, 0, 65536, 0, 0, 1'b1));
        send_sample(make_sample(32'sh0003_0000, -32'sh0005_0000, 32'sh0001_0000,
                                30000, 20000, 15536, 1'b1));

        set_config(32'hA5A5_A5A4 | CLAMP_POS_ONLY, COLOR_RGB, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
        send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(-32'sh0004_0000, -1, 32'sh8000_0000,
                                20000, 20000, 25536, 1'b1));

        set_config(CLAMP_NEG_ONLY, 32'h5A5A_5A58 | COLOR_RED_BLUE, 32'h8000_0000,
                   32'hFFFF_FFFF);
        send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(-1, 0, 0, 65536, 0, 0, 1'b1));
        send_sample(make_sample(32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0000_0001,
                                65536, 65536, 65536, 1'b1));
        send_sample(make_sample(-32'sh0002_0000, 32'sh0006_0000, -32'sh0000_4000,
                                40000, 10000, 15536, 1'b1));

        set_config(CLAMP_NONE, COLOR_RED_BLUE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 0,
                                65536, 65536, 0, 1'b1));
        send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
                                65536, 65536, 0, 1'b1));

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3),
                       ($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3),
                       random_low(), random_gain());
            // no idling at all in the closing phases
            idle_on  = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            stall_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < BEATS_PER_PHASE; n++)
                send_sample(random_sample());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        drain();
        if (fail_count == 0)
            $display("** curvature_color_mapper: PASSED **");
        else
            $display("** curvature_color_mapper: FAILED **");
        $finish;
    end

endmodule
